FILE: rtl/wcg_pkg.sv
// ============================================================================
// wcg_pkg
// Shared types and constants of the window coefficient generator: window
// codes, register indexes, fixed-point constants and sine series tables.
// ============================================================================
package wcg_pkg;

    // Window shapes, as written to the window type register
    typedef enum logic [1:0] {
        WIN_HANN      = 2'd0,
        WIN_SQRT_HANN = 2'd1,
        WIN_HAMMING   = 2'd2,
        WIN_RECT      = 2'd3
    } window_type_t;

    // Register indexes on the configuration port (byte address / 4)
    localparam logic REG_WINDOW_TYPE   = 1'b0;
    localparam logic REG_WINDOW_LENGTH = 1'b1;

    localparam int FRAC_BITS  = 16;
    localparam int COEF_W     = FRAC_BITS + 1;
    localparam int MAX_LENGTH = 4096;
    localparam int INDEX_W    = 12;
    localparam int LENGTH_W   = 13;

    localparam logic [COEF_W-1:0]   COEF_ONE       = COEF_W'(1) << FRAC_BITS;
    localparam logic [LENGTH_W-1:0] LENGTH_RESET   = 13'd1024;

    // pi in Q47, split for two narrow multipliers
    localparam logic [48:0] PI_Q47 = 49'h1921FB54442D2;
    localparam logic [23:0] PI_LO  = PI_Q47[23:0];
    localparam logic [24:0] PI_HI  = PI_Q47[48:24];

    // Taylor series of sin: term k is divided by (2k)(2k+1)
    localparam int SERIES_TERMS = 8;
    localparam logic [8:0] SERIES_DIV [SERIES_TERMS] = '{
        9'd6, 9'd20, 9'd42, 9'd72, 9'd110, 9'd156, 9'd210, 9'd272
    };
    // floor(2^34 / divisor); the quotient is corrected by one step afterwards
    localparam logic [31:0] SERIES_RECIP [SERIES_TERMS] = '{
        32'd2863311530, 32'd858993459, 32'd409044504, 32'd238609294,
        32'd156180628,  32'd110127366, 32'd81808900,  32'd63161283
    };

    // ceil(2^32 / 100): exact floor division by 100 for values below 2^23
    localparam logic [25:0] RECIP_100 = 26'd42949673;

    // Configuration seen by the output shaper
    typedef struct packed {
        window_type_t window_type;
        logic         short_win;
    } wcg_cfg_t;

endpackage

FILE: rtl/window_coefficient_generator.sv
// ============================================================================
// window_coefficient_generator
// Returns the Hann, square-root Hann, Hamming or rectangle coefficient for
// each sample index, unsigned with 16 fraction bits.
// ============================================================================
//
//   channel  direction  handshake          payload
//   s_       in         s_valid/s_ready    s_sample_index[11:0]
//   m_       out        m_valid/m_ready    m_coefficient[16:0]
//   apb      in         psel/penable/...   window_type @0x0, window_length @0x4
//
// One item per cycle sustained while the output is not blocked. The 60-bit
// restoring divider (15 stages) and the sine series (27 stages) are the deepest parts.
// All stages advance together; they hold while a result waits at the output
// and the last stage is full, and a bubble in the last stage still moves.
// Reset clears the valid bits and sets Hann with length 1024.
//
module window_coefficient_generator
    import wcg_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [INDEX_W-1:0]  s_sample_index,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [COEF_W-1:0]   m_coefficient,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    // Configuration registers
    window_type_t        window_type_reg;
    logic [LENGTH_W-1:0] window_length_reg;
    logic                cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_type_reg   <= WIN_HANN;
            window_length_reg <= LENGTH_RESET;
        end else if (cfg_write) begin
            unique case (paddr[2])
                REG_WINDOW_TYPE:   window_type_reg   <= window_type_t'(pwdata[1:0]);
                REG_WINDOW_LENGTH: window_length_reg <= pwdata[LENGTH_W-1:0];
                default:           window_type_reg   <= window_type_reg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_WINDOW_TYPE:   prdata = {30'd0, window_type_reg};
            REG_WINDOW_LENGTH: prdata = {19'd0, window_length_reg};
            default:           prdata = '0;
        endcase
    end

    // Derived window constants: clipped length and period
    logic [LENGTH_W-1:0] len_clip;
    logic [INDEX_W-1:0]  period;
    wcg_cfg_t            shape_cfg;

    assign len_clip = (window_length_reg > LENGTH_W'(MAX_LENGTH))
                      ? LENGTH_W'(MAX_LENGTH) : window_length_reg;
    assign period   = INDEX_W'(len_clip - LENGTH_W'(1));
    assign shape_cfg.window_type = window_type_reg;
    assign shape_cfg.short_win   = (len_clip < LENGTH_W'(2));

    // Pipeline advance: move unless a finished item is blocked
    logic              en;
    logic              out_free;
    logic              last_vld;
    logic [COEF_W-1:0] last_coef;
    logic              m_valid_reg;
    logic [COEF_W-1:0] m_coef_reg;

    assign out_free = !m_valid_reg || m_ready;
    assign en       = out_free || !last_vld;
    assign s_ready  = en;

    // Input stage: take the item, flag whether it lies inside the window
    logic               in_vld_reg;
    logic [INDEX_W-1:0] in_idx_reg;
    logic               in_win_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (en) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            in_idx_reg <= s_sample_index;
            in_win_reg <= (LENGTH_W'(s_sample_index) < len_clip);
        end
    end

    // Index modulo period
    logic               mod_vld;
    logic [INDEX_W-1:0] mod_rem;
    logic               mod_tag;

    wcg_divider #(
        .NUM_W (INDEX_W),
        .DEN_W (INDEX_W),
        .STEPS (3),
        .TAG_W (1)
    ) u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .den       (period),
        .in_valid  (in_vld_reg),
        .in_num    (in_idx_reg),
        .in_tag    (in_win_reg),
        .out_valid (mod_vld),
        .out_quot  (),
        .out_rem   (mod_rem),
        .out_tag   (mod_tag)
    );

    // Fold onto the first half of the period
    logic [INDEX_W-1:0] mirror;
    logic [10:0]        u_next;
    logic               u_vld_reg;
    logic [10:0]        u_reg;
    logic               u_tag_reg;

    assign mirror = period - mod_rem;
    assign u_next = 11'((mod_rem <= mirror) ? mod_rem : mirror);

    // Angle numerator u * pi, in two partial products
    logic        mul_vld_reg;
    logic [34:0] mul_lo_reg;
    logic [35:0] mul_hi_reg;
    logic        mul_tag_reg;
    logic        num_vld_reg;
    logic [59:0] num_reg;
    logic        num_tag_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            u_vld_reg   <= 1'b0;
            mul_vld_reg <= 1'b0;
            num_vld_reg <= 1'b0;
        end else if (en) begin
            u_vld_reg   <= mod_vld;
            mul_vld_reg <= u_vld_reg;
            num_vld_reg <= mul_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            u_reg       <= u_next;
            u_tag_reg   <= mod_tag;
            mul_lo_reg  <= 35'(u_reg) * 35'(PI_LO);
            mul_hi_reg  <= 36'(u_reg) * 36'(PI_HI);
            mul_tag_reg <= u_tag_reg;
            num_reg     <= (60'(mul_hi_reg) << 24) + 60'(mul_lo_reg);
            num_tag_reg <= mul_tag_reg;
        end
    end

    // Angle pi*u/period in Q47
    logic        ang_vld;
    logic [59:0] ang_quot;
    logic        ang_tag;

    wcg_divider #(
        .NUM_W (60),
        .DEN_W (INDEX_W),
        .STEPS (4),
        .TAG_W (1)
    ) u_angle (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .den       (period),
        .in_valid  (num_vld_reg),
        .in_num    (num_reg),
        .in_tag    (num_tag_reg),
        .out_valid (ang_vld),
        .out_quot  (ang_quot),
        .out_rem   (),
        .out_tag   (ang_tag)
    );

    logic        sin_vld;
    logic [31:0] sin_val;
    logic        sin_tag;

    wcg_sine u_sine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (ang_vld),
        .in_angle  (ang_quot[47:0]),
        .in_tag    (ang_tag),
        .out_valid (sin_vld),
        .out_sine  (sin_val),
        .out_tag   (sin_tag)
    );

    wcg_shape u_shape (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .cfg       (shape_cfg),
        .in_valid  (sin_vld),
        .in_sine   (sin_val),
        .in_tag    (sin_tag),
        .out_valid (last_vld),
        .out_coef  (last_coef)
    );

    // Output register: load whenever it is free, hold otherwise
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= last_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            m_coef_reg <= last_coef;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_coefficient = m_coef_reg;

    // An empty output never blocks the input
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input blocked with empty output");

    // A blocked result with a full last stage freezes the pipeline
    a_hold_when_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready && last_vld) |-> !s_ready)
        else $error("pipeline advanced over a blocked item");

    // No coefficient above 1.0
    a_coef_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_coefficient <= COEF_ONE))
        else $error("coefficient above one");

    // Rectangle gives only 0 or 1.0
    a_rect_values: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && window_type_reg == WIN_RECT)
            |-> (m_coefficient == COEF_ONE || m_coefficient == '0))
        else $error("rectangle value neither zero nor one");

endmodule

FILE: rtl/wcg_divider.sv
// ============================================================================
// wcg_divider
// Pipelined restoring divider, a few quotient bits per stage, tag per item.
// The user keeps the divisor static while items are in flight; not enforced.
// ============================================================================
module wcg_divider #(
    parameter int NUM_W = 12,
    parameter int DEN_W = 12,
    parameter int STEPS = 3,
    parameter int TAG_W = 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic [DEN_W-1:0] den,
    input  logic             in_valid,
    input  logic [NUM_W-1:0] in_num,
    input  logic [TAG_W-1:0] in_tag,
    output logic             out_valid,
    output logic [NUM_W-1:0] out_quot,
    output logic [DEN_W-1:0] out_rem,
    output logic [TAG_W-1:0] out_tag
);

    localparam int STAGES = (NUM_W + STEPS - 1) / STEPS;

    logic             vld_reg [STAGES];
    logic [NUM_W-1:0] quot_reg [STAGES];
    logic [DEN_W-1:0] rem_reg [STAGES];
    logic [TAG_W-1:0] tag_reg [STAGES];

    for (genvar gs = 0; gs < STAGES; gs++) begin : g_stage
        logic             vld_in;
        logic [NUM_W-1:0] quot_in;
        logic [DEN_W-1:0] rem_in;
        logic [TAG_W-1:0] tag_in;
        logic [NUM_W-1:0] quot_next;
        logic [DEN_W-1:0] rem_next;

        if (gs == 0) begin : g_first
            assign vld_in  = in_valid;
            assign quot_in = in_num;
            assign rem_in  = '0;
            assign tag_in  = in_tag;
        end else begin : g_rest
            assign vld_in  = vld_reg[gs-1];
            assign quot_in = quot_reg[gs-1];
            assign rem_in  = rem_reg[gs-1];
            assign tag_in  = tag_reg[gs-1];
        end

        // Shift one dividend bit in per step, subtract where it fits
        always_comb begin
            logic [DEN_W:0]   ext_v;
            logic [NUM_W-1:0] q_v;
            logic [DEN_W-1:0] r_v;
            q_v   = quot_in;
            r_v   = rem_in;
            ext_v = '0;
            for (int j = 0; j < STEPS; j++) begin
                if (gs * STEPS + j < NUM_W) begin
                    ext_v = {r_v, q_v[NUM_W-1]};
                    q_v   = {q_v[NUM_W-2:0], 1'b0};
                    if (ext_v >= {1'b0, den}) begin
                        ext_v  = ext_v - {1'b0, den};
                        q_v[0] = 1'b1;
                    end
                    r_v = ext_v[DEN_W-1:0];
                end
            end
            quot_next = q_v;
            rem_next  = r_v;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[gs] <= 1'b0;
            end else if (en) begin
                vld_reg[gs] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                quot_reg[gs] <= quot_next;
                rem_reg[gs]  <= rem_next;
                tag_reg[gs]  <= tag_in;
            end
        end
    end

    assign out_valid = vld_reg[STAGES-1];
    assign out_quot  = quot_reg[STAGES-1];
    assign out_rem   = rem_reg[STAGES-1];
    assign out_tag   = tag_reg[STAGES-1];

endmodule

FILE: rtl/wcg_sine.sv
// ============================================================================
// wcg_sine
// Rounds the Q47 angle to Q31 and evaluates sin by a nine-term Taylor
// series, three stages per term, then limits the sum to 1.0 in Q31.
// ============================================================================
module wcg_sine
    import wcg_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic        in_valid,
    input  logic [47:0] in_angle,
    input  logic        in_tag,
    output logic        out_valid,
    output logic [31:0] out_sine,
    output logic        out_tag
);

    localparam logic [33:0] ONE_Q31 = 34'h080000000;

    // Round angle to Q31
    logic [47:0] rnd_sum;
    logic [31:0] y_next;
    logic        y_vld_reg;
    logic [31:0] y_reg;
    logic        y_tag_reg;

    assign rnd_sum = in_angle + 48'h8000;
    assign y_next  = rnd_sum[47:16];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            y_vld_reg <= 1'b0;
        end else if (en) begin
            y_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            y_reg     <= y_next;
            y_tag_reg <= in_tag;
        end
    end

    // Square of the angle
    logic [63:0] ysq_full;
    logic [32:0] y2_next;
    logic        q_vld_reg;
    logic [31:0] q_term_reg;
    logic [32:0] q_y2_reg;
    logic        q_tag_reg;

    assign ysq_full = 64'(y_reg) * 64'(y_reg);
    assign y2_next  = ysq_full[63:31];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_vld_reg <= 1'b0;
        end else if (en) begin
            q_vld_reg <= y_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q_term_reg <= y_reg;
            q_y2_reg   <= y2_next;
            q_tag_reg  <= y_tag_reg;
        end
    end

    // Chain between series terms: sum holds terms before the pending one
    logic        chain_vld  [SERIES_TERMS+1];
    logic        chain_tag  [SERIES_TERMS+1];
    logic [31:0] chain_term [SERIES_TERMS+1];
    logic [33:0] chain_sum  [SERIES_TERMS+1];
    logic [32:0] chain_y2   [SERIES_TERMS+1];

    assign chain_vld[0]  = q_vld_reg;
    assign chain_tag[0]  = q_tag_reg;
    assign chain_term[0] = q_term_reg;
    assign chain_sum[0]  = '0;
    assign chain_y2[0]   = q_y2_reg;

    for (genvar gi = 0; gi < SERIES_TERMS; gi++) begin : g_term
        logic [64:0] p_full;
        logic [33:0] p_sum_next;
        logic        p_vld_reg;
        logic [33:0] p_prod_reg;
        logic [33:0] p_sum_reg;
        logic [32:0] p_y2_reg;
        logic        p_tag_reg;
        logic [65:0] r_full;
        logic        r_vld_reg;
        logic [31:0] r_q0_reg;
        logic [33:0] r_prod_reg;
        logic [33:0] r_sum_reg;
        logic [32:0] r_y2_reg;
        logic        r_tag_reg;
        logic [41:0] c_rem;
        logic [31:0] c_term_next;
        logic        c_vld_reg;
        logic [31:0] c_term_reg;
        logic [33:0] c_sum_reg;
        logic [32:0] c_y2_reg;
        logic        c_tag_reg;

        // Multiply by the squared angle; fold the pending term into the sum
        assign p_full = 65'(chain_term[gi]) * 65'(chain_y2[gi]);
        if ((gi % 2) == 1) begin : g_sub
            assign p_sum_next = chain_sum[gi] - 34'(chain_term[gi]);
        end else begin : g_add
            assign p_sum_next = chain_sum[gi] + 34'(chain_term[gi]);
        end

        // Estimate the quotient by the reciprocal
        assign r_full = 66'(p_prod_reg) * 66'(SERIES_RECIP[gi]);

        // Correct the estimate by one where the remainder allows
        assign c_rem = 42'(r_prod_reg) - 42'(r_q0_reg) * 42'(SERIES_DIV[gi]);
        assign c_term_next = r_q0_reg + 32'(c_rem >= 42'(SERIES_DIV[gi]));

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                p_vld_reg <= 1'b0;
                r_vld_reg <= 1'b0;
                c_vld_reg <= 1'b0;
            end else if (en) begin
                p_vld_reg <= chain_vld[gi];
                r_vld_reg <= p_vld_reg;
                c_vld_reg <= r_vld_reg;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                p_prod_reg <= p_full[64:31];
                p_sum_reg  <= p_sum_next;
                p_y2_reg   <= chain_y2[gi];
                p_tag_reg  <= chain_tag[gi];
                r_q0_reg   <= r_full[65:34];
                r_prod_reg <= p_prod_reg;
                r_sum_reg  <= p_sum_reg;
                r_y2_reg   <= p_y2_reg;
                r_tag_reg  <= p_tag_reg;
                c_term_reg <= c_term_next;
                c_sum_reg  <= r_sum_reg;
                c_y2_reg   <= r_y2_reg;
                c_tag_reg  <= r_tag_reg;
            end
        end

        assign chain_vld[gi+1]  = c_vld_reg;
        assign chain_tag[gi+1]  = c_tag_reg;
        assign chain_term[gi+1] = c_term_reg;
        assign chain_sum[gi+1]  = c_sum_reg;
        assign chain_y2[gi+1]   = c_y2_reg;
    end

    // Add the last term and limit to 1.0
    logic [33:0] fin_sum;
    logic [31:0] sine_next;
    logic        fin_vld_reg;
    logic [31:0] fin_sine_reg;
    logic        fin_tag_reg;

    if ((SERIES_TERMS % 2) == 1) begin : g_fin_sub
        assign fin_sum = chain_sum[SERIES_TERMS] - 34'(chain_term[SERIES_TERMS]);
    end else begin : g_fin_add
        assign fin_sum = chain_sum[SERIES_TERMS] + 34'(chain_term[SERIES_TERMS]);
    end
    assign sine_next = (fin_sum > ONE_Q31) ? ONE_Q31[31:0] : fin_sum[31:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_vld_reg <= 1'b0;
        end else if (en) begin
            fin_vld_reg <= chain_vld[SERIES_TERMS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fin_sine_reg <= sine_next;
            fin_tag_reg  <= chain_tag[SERIES_TERMS];
        end
    end

    assign out_valid = fin_vld_reg;
    assign out_sine  = fin_sine_reg;
    assign out_tag   = fin_tag_reg;

endmodule

FILE: rtl/wcg_shape.sv
// ============================================================================
// wcg_shape
// Turns sin(pi*x) in Q31 into the Hann, square-root Hann or Hamming value,
// or the rectangle value, rounded to the output fraction width.
// ============================================================================
module wcg_shape
    import wcg_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  wcg_cfg_t          cfg,
    input  logic              in_valid,
    input  logic [31:0]       in_sine,
    input  logic              in_tag,
    output logic              out_valid,
    output logic [COEF_W-1:0] out_coef
);

    // Square the sine
    logic [63:0] sq_full;
    logic        a_vld_reg;
    logic [62:0] a_sq_reg;
    logic [31:0] a_sine_reg;
    logic        a_tag_reg;

    assign sq_full = 64'(in_sine) * 64'(in_sine);

    // Round Hann and square-root Hann, scale Hamming down to Q16 * 100
    logic [63:0] hann_sum;
    logic [32:0] sqrt_sum;
    logic [47:0] ham_v;
    logic        b_vld_reg;
    logic [COEF_W-1:0] b_hann_reg;
    logic [COEF_W-1:0] b_sqrt_reg;
    logic [22:0] b_ham_x_reg;
    logic        b_tag_reg;

    assign hann_sum = 64'(a_sq_reg) + (64'd1 << 45);
    assign sqrt_sum = 33'(a_sine_reg) + (33'd1 << 14);
    assign ham_v    = (48'd8 << 40) + 48'd92 * 48'(a_sq_reg[62:22]) + (48'd50 << 24);

    // Divide Hamming by 100 and pick the window
    logic [48:0]       ham_full;
    logic [COEF_W-1:0] coef_next;

    assign ham_full = 49'(b_ham_x_reg) * 49'(RECIP_100);

    always_comb begin
        coef_next = COEF_ONE;
        if (cfg.window_type == WIN_RECT) begin
            coef_next = b_tag_reg ? COEF_ONE : '0;
        end else if (!cfg.short_win) begin
            unique case (cfg.window_type)
                WIN_HANN:      coef_next = b_hann_reg;
                WIN_SQRT_HANN: coef_next = b_sqrt_reg;
                WIN_HAMMING:   coef_next = ham_full[48:32];
                default:       coef_next = COEF_ONE;
            endcase
        end
    end

    logic              c_vld_reg;
    logic [COEF_W-1:0] c_coef_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
        end else if (en) begin
            a_vld_reg <= in_valid;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_sq_reg    <= sq_full[62:0];
            a_sine_reg  <= in_sine;
            a_tag_reg   <= in_tag;
            b_hann_reg  <= hann_sum[62:46];
            b_sqrt_reg  <= sqrt_sum[31:15];
            b_ham_x_reg <= ham_v[46:24];
            b_tag_reg   <= a_tag_reg;
            c_coef_reg  <= coef_next;
        end
    end

    assign out_valid = c_vld_reg;
    assign out_coef  = c_coef_reg;

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for window_coefficient_generator. Each index sent is
// scored by an integer model of the Hann, square-root Hann, Hamming and
// rectangle windows. Each coefficient that comes back is compared in order.
// Window settings are written over APB while the pipeline is empty.
// ============================================================================
module tb;
    import wcg_pkg::*;

    localparam int  LATENCY     = 54;
    localparam int  CYCLE_LIMIT = 400000;
    localparam logic [63:0] PI_FIX = 64'h1921FB54442D2;
    localparam logic [2:0]  ADDR_TYPE   = 3'({REG_WINDOW_TYPE, 2'b00});
    localparam logic [2:0]  ADDR_LENGTH = 3'({REG_WINDOW_LENGTH, 2'b00});

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [INDEX_W-1:0]  s_sample_index;
    logic                m_valid;
    logic                m_ready;
    logic [COEF_W-1:0]   m_coefficient;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [2:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    // Window settings as the bench believes them to be
    window_type_t        model_type;
    logic [LENGTH_W-1:0] model_length;

    logic [COEF_W-1:0]   expected_coefs[$];
    int                  error_count;
    int                  coef_count;
    int                  cycle_count;
    int                  stall_left;
    bit                  idling;

    window_coefficient_generator dut (.*);

    // Clock
    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d coefficients pending", $time, expected_coefs.size());
            $display("window_coefficient_generator verification failed");
            $finish;
        end
    end

    // Integer window model: sin(pi*u/m) by truncated Taylor series in Q31
    function automatic logic [COEF_W-1:0] window_coef(input logic [INDEX_W-1:0] idx);
        logic [63:0] n, m, r, u, y, y2, term, sum, sq, w, v, d, divisor;
        n = 64'(model_length);
        if (n > MAX_LENGTH)
            n = MAX_LENGTH;
        if (model_type == WIN_RECT)
            return (64'(idx) < n) ? COEF_ONE : '0;
        if (n < 2)
            return COEF_ONE;
        m = n - 1;
        r = 64'(idx) % m;
        u = (r <= m - r) ? r : m - r;
        y = ((u * PI_FIX) / m + 64'h8000) >> 16;
        y2 = (y * y) >> 31;
        term = y;
        sum = y;
        for (int k = 1; k <= 8; k++) begin
            divisor = 64'((2 * k) * (2 * k + 1));
            term = ((term * y2) >> 31) / divisor;
            if (k % 2 == 1)
                sum = sum - term;
            else
                sum = sum + term;
        end
        if (sum > 64'h80000000)
            sum = 64'h80000000;
        if (model_type == WIN_SQRT_HANN)
            return COEF_W'((sum + (64'd1 << (30 - FRAC_BITS))) >> (31 - FRAC_BITS));
        sq = sum * sum;
        if (model_type == WIN_HANN)
            return COEF_W'((sq + (64'd1 << (61 - FRAC_BITS))) >> (62 - FRAC_BITS));
        w = sq >> 22;
        v = (64'd8 << 40) + 64'd92 * w;
        d = 64'd100 << (40 - FRAC_BITS);
        return COEF_W'((v + d / 2) / d);
    endfunction

    // Result stall in random bursts
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b1;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= (stall_left == 1);
        end else if (idling && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(1, 8);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Score each coefficient against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            coef_count <= coef_count + 1;
            if (expected_coefs.size() == 0) begin
                $display("%0t: unexpected coefficient %0d", $time, m_coefficient);
                error_count <= error_count + 1;
            end else begin
                if (m_coefficient !== expected_coefs[0]) begin
                    $display("%0t: coefficient expected %0d actual %0d",
                             $time, expected_coefs[0], m_coefficient);
                    error_count <= error_count + 1;
                end
                void'(expected_coefs.pop_front());
            end
        end
    end

    // Send one index, with an optional gap ahead of it
    task automatic send_index(input logic [INDEX_W-1:0] idx);
        if (idling && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_sample_index <= idx;
        do @(posedge aclk); while (!s_ready);
        expected_coefs.push_back(window_coef(idx));
        @(negedge aclk);
    endtask

    // Drop valid and let the pipeline empty
    task automatic drain;
        s_valid <= 1'b0;
        wait (expected_coefs.size() == 0);
        repeat (LATENCY + 4) @(negedge aclk);
    endtask

    // APB write: setup then access, then back to idle
    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (addr == ADDR_TYPE)
            model_type = window_type_t'(data[1:0]);
        else if (addr == ADDR_LENGTH)
            model_length = data[LENGTH_W-1:0];
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_window(input window_type_t kind, input logic [LENGTH_W-1:0] len);
        apb_write(ADDR_TYPE, 32'(kind));
        apb_write(ADDR_LENGTH, 32'(len));
    endtask

    // Reset values: Hann over 1024 points
    task automatic test_reset_window;
        send_index('0);
        send_index(12'd511);
        send_index(12'd1023);
        send_index(12'd4095);
        drain();
    endtask

    // Each window at the edges of length and index
    task automatic test_directed_edges;
        logic [LENGTH_W-1:0] lens[3];
        lens = '{13'd1, 13'd2, 13'd8191};
        for (int t = 0; t < 4; t++) begin
            for (int l = 0; l < 3; l++) begin
                set_window(window_type_t'(t), lens[l]);
                send_index('0);
                send_index(12'd1);
                send_index(12'd2048);
                send_index(12'd4095);
                drain();
            end
        end
    endtask

    // Random windows and indexes, mostly moderate lengths
    task automatic test_random_windows(input int phases, input int per_phase);
        logic [LENGTH_W-1:0] len;
        for (int p = 0; p < phases; p++) begin
            case ($urandom_range(0, 4))
                0: len = 13'($urandom_range(0, 8191));
                1: len = 13'($urandom_range(4090, 4100));
                default: len = 13'($urandom_range(2, 300));
            endcase
            set_window(window_type_t'($urandom_range(0, 3)), len);
            for (int i = 0; i < per_phase; i++) begin
                if ($urandom_range(0, 1))
                    send_index(12'($urandom_range(0, 4095)));
                else
                    send_index(12'($urandom_range(0, 32'(len) + 4)));
            end
            drain();
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_sample_index = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        m_ready = 1'b1;
        model_type = WIN_HANN;
        model_length = LENGTH_RESET;
        error_count = 0;
        coef_count = 0;
        cycle_count = 0;
        stall_left = 0;
        idling = 1'b1;
        repeat (9) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_reset_window();
        test_directed_edges();
        test_random_windows(12, 115);
        idling = 1'b0;
        test_random_windows(2, 80);

        $display("Checked %0d coefficients over all four windows, lengths 0 to 8191,",
                 coef_count);
        $display("with random gaps and output stalls, then a final stretch at full rate.");
        if (error_count == 0)
            $display("window_coefficient_generator verification clean");
        else
            $display("window_coefficient_generator verification failed");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/wcg_pkg.sv
rtl/wcg_divider.sv
rtl/wcg_sine.sv
rtl/wcg_shape.sv
rtl/window_coefficient_generator.sv
bench/tb.sv
